/* rtl/core/drc_pkg.sv */
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants of the dynamic resolution controller.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int unsigned PERIOD_W   = 20;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned CHANGE_W   = 15;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned COOLDOWN_W = PERIOD_W + 1;
  localparam int unsigned PROD_W     = CHANGE_W + TIME_W;
  localparam int unsigned DIV_STEPS  = PROD_W;
  localparam int unsigned COUNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANGE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TIME   = 3'd3;

  localparam logic [PERIOD_W-1:0] RST_PERIOD = 20'd300000;
  localparam logic [TIME_W-1:0]   RST_DEAD   = 16'd77;
  localparam logic [CHANGE_W-1:0] RST_MAXCHG = 15'd8192;
  localparam logic [TIME_W-1:0]   RST_TARGET = 16'd776;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } state_t;

endpackage

/* rtl/core/dynamic_resolution_controller_core.sv */
// ----------------------------------------------------------------------------
// dynamic_resolution_controller_core
// A skipped tick (disabled, cooldown running, error in the dead band) goes from check
// straight to the output stage; with zero target time it passes through apply, and
// otherwise through multiply, the 31-step restoring divider and apply. One tick is in
// flight at a time; a new one is taken while a finished result still waits on the output.
// Reset: synchronous; registers, cooldown and scale take their reset values.
// ----------------------------------------------------------------------------
module dynamic_resolution_controller_core
  import drc_pkg::*;
#(
  parameter int unsigned SCALE_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data,
  // input ticks
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,  // [19:0] elapsed_us, [35:20] measured_time
  input  logic [0:0]           s_tuser,  // [0] enable
  // results
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,  // [15:0] scale
  output logic [0:0]           m_tuser   // [0] updated
);

  localparam int unsigned UNITY_RAW = 32'd1 << SCALE_FRAC_BITS;
  localparam int unsigned UNITY     = (UNITY_RAW > 32'd65535) ? 32'd65535 : UNITY_RAW;

  state_t state, state_next;

  logic [PERIOD_W-1:0]   update_period;
  logic [TIME_W-1:0]     dead_zone;
  logic [CHANGE_W-1:0]   max_change;
  logic [TIME_W-1:0]     target_time;
  logic [COOLDOWN_W-1:0] cooldown;
  logic [SCALE_W-1:0]    scale;

  logic                  in_enable;
  logic [PERIOD_W-1:0]   in_elapsed;
  logic [TIME_W-1:0]     in_measured;
  logic                  err_neg;
  logic [TIME_W-1:0]     mag;
  logic [PROD_W-1:0]     work;
  logic [TIME_W-1:0]     rem;
  logic [COUNT_W-1:0]    count;
  logic                  updated;

  logic [COOLDOWN_W:0]   cool_diff;
  logic                  cool_pos;
  logic [TIME_W:0]       err;
  logic [TIME_W:0]       err_abs;
  logic                  in_band;
  logic [TIME_W:0]       rem_shift;
  logic                  rem_ge;
  logic [TIME_W:0]       rem_sub;
  logic [CHANGE_W-1:0]   step;
  logic [SCALE_W+1:0]    sum;
  logic [SCALE_W-1:0]    scale_next;
  logic                  out_free;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_period <= RST_PERIOD;
      dead_zone     <= RST_DEAD;
      max_change    <= RST_MAXCHG;
      target_time   <= RST_TARGET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UPDATE_PERIOD: update_period <= cfg_data;
        REG_DEAD_ZONE:     dead_zone     <= cfg_data[TIME_W-1:0];
        REG_MAX_CHANGE:    max_change    <= cfg_data[CHANGE_W-1:0];
        REG_TARGET_TIME:   target_time   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // tick evaluation
  assign cool_diff = {cooldown[COOLDOWN_W-1], cooldown} - {2'b00, in_elapsed};
  assign cool_pos  = !cool_diff[COOLDOWN_W] && (cool_diff != '0);
  assign err       = {1'b0, target_time} - {1'b0, in_measured};
  assign err_abs   = err[TIME_W] ? (~err + 1'b1) : err;
  assign in_band   = err_abs[TIME_W-1:0] < dead_zone;

  // divider step
  assign rem_shift = {rem, work[PROD_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, target_time};
  assign rem_sub   = rem_shift - {1'b0, target_time};

  // scale update
  assign step = (work > {{(PROD_W-CHANGE_W){1'b0}}, max_change}) ? max_change
              : work[CHANGE_W-1:0];
  assign sum  = err_neg ? ({2'b00, scale} - {3'b000, step})
                        : ({2'b00, scale} + {3'b000, step});

  always_comb begin
    if (sum[SCALE_W+1]) begin
      scale_next = '0;
    end else if (sum[SCALE_W]) begin
      scale_next = '1;
    end else begin
      scale_next = sum[SCALE_W-1:0];
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!in_enable || cool_pos || in_band) begin
          state_next = ST_FINISH;
        end else if (target_time == '0) begin
          state_next = ST_APPLY;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        if (count == COUNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown <= {1'b0, RST_PERIOD};
      scale    <= SCALE_W'(UNITY);
    end else begin
      if (state == ST_CHECK && in_enable) begin
        cooldown <= cool_pos ? cool_diff[COOLDOWN_W-1:0] : {1'b0, update_period};
      end
      if (state == ST_APPLY) begin
        scale <= scale_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        in_enable   <= s_tuser[0];
        in_elapsed  <= s_tdata[19:0];
        in_measured <= s_tdata[35:20];
      end
      ST_CHECK: begin
        updated <= 1'b0;
        err_neg <= err[TIME_W];
        mag     <= err_abs[TIME_W-1:0];
        work    <= {{(PROD_W-CHANGE_W){1'b0}}, max_change};
      end
      ST_MUL: begin
        work  <= PROD_W'(max_change * mag);
        rem   <= '0;
        count <= '0;
      end
      ST_DIV: begin
        rem   <= rem_ge ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
        work  <= {work[PROD_W-2:0], rem_ge};
        count <= count + 1'b1;
      end
      ST_APPLY: updated <= scale_next != scale;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata    <= scale;
      m_tuser[0] <= updated;
    end
  end

  // checks
  a_cooldown_nonneg: assert property (@(posedge clk) disable iff (rst)
    !cooldown[COOLDOWN_W-1])
    else $error("cooldown went negative");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (count < COUNT_W'(DIV_STEPS)))
    else $error("divider ran past its last step");

  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second tick taken while one is in flight");

  a_apply_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |=> (state == ST_FINISH))
    else $error("scale update did not reach the output stage");

endmodule
